### src/offset_argmax_confusion_scorer_core_macros.svh
// Assertion macros for the offset argmax confusion scorer core.
// Used by the top level only; no other dependencies.
`ifndef OFFSET_ARGMAX_CONFUSION_SCORER_CORE_MACROS_SVH
`define OFFSET_ARGMAX_CONFUSION_SCORER_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define OACS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define OACS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

### src/oacs_pkg.sv
// Package for the offset argmax confusion scorer: widths, codes and
// controller/datapath command and status structs. No dependencies.
package oacs_pkg;
   localparam int PROB_BITS   = 16;
   localparam int OFFSET_BITS = 20;
   localparam int SCORE_BITS  = 17;
   localparam int NUM_INPUTS  = 4;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 20;
   localparam int DIV_BITS = 64;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CLASS_COUNT = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CRITERION   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OFFSET_0    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OFFSET_3    = 3'd5;

   localparam logic CRIT_ACCURACY = 1'b0;
   localparam logic CRIT_BALANCED = 1'b1;

   // Commands from controller to datapath.
   typedef struct packed {
      logic take;       // latch the incoming word and count it
      logic sweep_clr;  // clear sweep accumulators
      logic sweep_step; // accumulate one row/column of the matrix
      logic div_start;  // launch the divider
      logic add_recall; // add divider quotient to the recall sum
      logic fin_start;  // launch the final divide
      logic clear;      // clear the matrix and the saturation flag
      logic rsp_load;   // load the response register
      logic rsp_score;  // the response carries a score
   } oacs_cmd_type;

   typedef struct packed {
      logic is_last;
      logic div_busy;
      logic sweep_done;
      logic crit_balanced;
   } oacs_status_type;
endpackage

### src/oacs_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on oacs_pkg.
module oacs_divider
   import oacs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIV_BITS-1:0] dividend,
   input  logic [DIV_BITS-1:0] divisor,
   output logic                busy,
   output logic [DIV_BITS-1:0] quotient
);
   localparam int CNT_BITS = $clog2(DIV_BITS + 1);
   logic [DIV_BITS-1:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [DIV_BITS:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[DIV_BITS-1]} - {1'b0, dvs_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_BITS'(DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIV_BITS]) begin
            rem_in = trial[DIV_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DIV_BITS-2:0], quo_ff[DIV_BITS-1]};
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

### src/oacs_datapath.sv
// Datapath: offset argmax, confusion matrix, sweep accumulators, response.
// Depends on oacs_pkg and oacs_divider.
module oacs_datapath
   import oacs_pkg::*;
#(
   parameter int MAX_CLASSES = 4,
   parameter int COUNT_BITS  = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  oacs_cmd_type                    cmd,
   output oacs_status_type                 status,
   input  logic [2:0]                      class_count,
   input  logic                            criterion,
   input  logic signed [OFFSET_BITS-1:0]   offsets [NUM_INPUTS],
   input  logic [PROB_BITS-1:0]            probs [NUM_INPUTS],
   input  logic [1:0]                      true_class,
   input  logic                            is_last,
   output logic [1:0]                      predicted_class,
   output logic [SCORE_BITS-1:0]           score,
   output logic                            score_valid,
   output logic                            count_overflow
);
   localparam int NCELLS   = MAX_CLASSES * MAX_CLASSES;
   localparam int CIDX     = $clog2(MAX_CLASSES);
   localparam int CELLIDX  = $clog2(NCELLS);
   localparam int LIM      = (MAX_CLASSES < NUM_INPUTS) ? MAX_CLASSES : NUM_INPUTS;
   localparam int SUM_BITS = COUNT_BITS + CIDX + CIDX;
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

   logic [COUNT_BITS-1:0] cells_ff [NCELLS];
   logic                  sat_ff;
   logic [2:0]            n_eff;
   logic [1:0]            best;
   logic [OFFSET_BITS:0]  sc [NUM_INPUTS];
   logic [1:0]            pred_ff;
   logic                  last_ff;
   logic                  count_ok_ff;
   logic [1:0]            truth_ff;
   logic [CELLIDX-1:0]    hit_idx;

   // Effective class count.
   always_comb begin
      n_eff = class_count;
      if (n_eff < 3'd2) n_eff = 3'd2;
      if (n_eff > 3'(LIM)) n_eff = 3'(LIM);
   end

   // Argmax over up to four lanes, lowest index winning ties.
   always_comb begin
      best = 2'd0;
      for (int k = 0; k < NUM_INPUTS; k++) begin
         sc[k] = $signed({5'b0, probs[k]}) + $signed({offsets[k][OFFSET_BITS-1], offsets[k]});
      end
      for (int k = 1; k < NUM_INPUTS; k++) begin
         if (3'(k) < n_eff && $signed(sc[k]) > $signed(sc[best])) best = 2'(k);
      end
   end

   assign hit_idx = CELLIDX'(({2'b0, pred_ff} * MAX_CLASSES) + {2'b0, truth_ff});

   // Sweep: index t walks the classes; accumulate column sum and diagonal.
   logic [CIDX:0]         t_ff;
   logic [SUM_BITS-1:0]   col_sum, diag_ff, total_ff, rsum_ff;
   logic [COUNT_BITS-1:0] diag_cell;
   logic [COUNT_BITS-1:0] dcell_ff;
   logic [CIDX:0]         present_ff;
   logic [SUM_BITS-1:0]   col_ff;
   logic                  div_start;
   logic [DIV_BITS-1:0]   div_a, div_b, quotient;
   logic                  div_busy;
   logic [2:0]            n_ff;

   always_comb begin
      col_sum = '0;
      for (int p = 0; p < MAX_CLASSES; p++) begin
         if (3'(p) < n_ff)
            col_sum = col_sum + SUM_BITS'(cells_ff[p*MAX_CLASSES + int'(t_ff[CIDX-1:0])]);
      end
      diag_cell = cells_ff[int'(t_ff[CIDX-1:0])*(MAX_CLASSES+1)];
   end

   assign status.sweep_done    = (t_ff >= (CIDX+1)'(n_ff)) || (t_ff == (CIDX+1)'(MAX_CLASSES));
   assign status.is_last       = last_ff;
   assign status.div_busy      = div_busy;
   assign status.crit_balanced = (criterion == CRIT_BALANCED);

   // The per-class recall divides the diagonal count held at the sweep step,
   // since the sweep index has already moved on by the time it starts.
   always_comb begin
      if (cmd.fin_start) begin
         if (criterion == CRIT_BALANCED) begin
            div_a = DIV_BITS'(rsum_ff);
            div_b = (present_ff == '0) ? DIV_BITS'(1) : DIV_BITS'(present_ff);
         end else begin
            div_a = DIV_BITS'(diag_ff) << 16;
            div_b = (total_ff == '0) ? DIV_BITS'(1) : DIV_BITS'(total_ff);
         end
      end else begin
         div_a = DIV_BITS'(dcell_ff) << 16;
         div_b = (col_ff == '0) ? DIV_BITS'(1) : DIV_BITS'(col_ff);
      end
   end
   assign div_start = cmd.div_start || cmd.fin_start;

   oacs_divider u_div (
      .clock, .reset, .start(div_start), .dividend(div_a), .divisor(div_b),
      .busy(div_busy), .quotient(quotient)
   );

   logic [SCORE_BITS-1:0] rsp_score_ff;
   logic [1:0]            rsp_pred_ff;
   logic                  rsp_valid_ff, rsp_ovf_ff;
   logic                  fin_empty;
   assign fin_empty = (criterion == CRIT_BALANCED) ? (present_ff == '0) : (total_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         pred_ff     <= best;
         truth_ff    <= true_class;
         last_ff     <= is_last;
         count_ok_ff <= ({1'b0, true_class} < n_eff);
         n_ff        <= n_eff;
      end
      if (cmd.sweep_clr) begin
         t_ff <= '0; diag_ff <= '0; total_ff <= '0; rsum_ff <= '0; present_ff <= '0;
      end else if (cmd.sweep_step) begin
         t_ff     <= t_ff + 1'b1;
         col_ff   <= col_sum;
         dcell_ff <= diag_cell;
         total_ff <= total_ff + col_sum;
         diag_ff  <= diag_ff + SUM_BITS'(diag_cell);
         if (col_sum != '0) present_ff <= present_ff + 1'b1;
      end
      if (cmd.add_recall && col_ff != '0) rsum_ff <= rsum_ff + SUM_BITS'(quotient);
      if (cmd.rsp_load) begin
         rsp_pred_ff  <= pred_ff;
         rsp_valid_ff <= cmd.rsp_score;
         rsp_ovf_ff   <= sat_ff;
         if (!cmd.rsp_score || fin_empty) rsp_score_ff <= '0;
         else if (quotient > DIV_BITS'(65536)) rsp_score_ff <= SCORE_BITS'(65536);
         else rsp_score_ff <= quotient[SCORE_BITS-1:0];
      end
   end

   // Matrix update in the cycle after an item is taken.
   logic count_pend_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         count_pend_ff <= 1'b0;
         sat_ff        <= 1'b0;
         for (int i = 0; i < NCELLS; i++) cells_ff[i] <= '0;
      end else begin
         count_pend_ff <= cmd.take;
         if (cmd.clear) begin
            sat_ff <= 1'b0;
            for (int i = 0; i < NCELLS; i++) cells_ff[i] <= '0;
         end else if (count_pend_ff && count_ok_ff) begin
            if (cells_ff[hit_idx] == CMAX) sat_ff <= 1'b1;
            else cells_ff[hit_idx] <= cells_ff[hit_idx] + 1'b1;
         end
      end
   end

   assign predicted_class = rsp_pred_ff;
   assign score           = rsp_score_ff;
   assign score_valid     = rsp_valid_ff;
   assign count_overflow  = rsp_ovf_ff;
endmodule

### src/oacs_ctrl.sv
// Controller state machine for the scorer.
// Depends on oacs_pkg.
module oacs_ctrl
   import oacs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  oacs_status_type status,
   output oacs_cmd_type    cmd
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_COUNT, ST_SWEEP, ST_DIV, ST_FIN, ST_FINWAIT, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      wait_ff, wait_in;
   logic      can_load;

   assign can_load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wait_in      = 1'b0;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (status.is_last) begin
               cmd.sweep_clr = 1'b1;
               state_in = ST_SWEEP;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SWEEP: begin
            if (status.sweep_done) begin
               cmd.fin_start = 1'b1;
               state_in = ST_FINWAIT;
            end else begin
               cmd.sweep_step = 1'b1;
               state_in = status.crit_balanced ? ST_DIV : ST_SWEEP;
            end
         end
         ST_DIV: begin
            if (!wait_ff) begin
               cmd.div_start = 1'b1;
               wait_in = 1'b1;
            end else if (status.div_busy) begin
               wait_in = 1'b1;
            end else begin
               cmd.add_recall = 1'b1;
               state_in = ST_SWEEP;
            end
         end
         ST_FINWAIT: begin
            if (!wait_ff || status.div_busy) wait_in = 1'b1;
            else state_in = ST_FIN;
         end
         ST_FIN: begin
            if (can_load) begin
               cmd.rsp_load  = 1'b1;
               cmd.rsp_score = 1'b1;
               cmd.clear     = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (can_load) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wait_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wait_ff      <= wait_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

### src/offset_argmax_confusion_scorer_core.sv
// Top level of the offset argmax confusion scorer: registers and wiring.
// Depends on oacs_pkg, oacs_ctrl, oacs_datapath and the macros header.
//
//   channel | ports                   | direction
//   req     | req_valid / req_stall   | in: one classified instance per word
//   rsp     | rsp_valid / rsp_stall   | out: prediction per word, score on a last word
//   csr     | csr_write_enable        | in: register writes, no read-back
//
// An ordinary word passes through three steps from acceptance to the response
// register: take, count into the matrix, load the response. A word marked
// last also sweeps the matrix one class per cycle; for balanced accuracy
// each class waits on the bit-serial divider, and the final divide waits
// on it as well, so the shared 64-bit divider sets the cost.
// Reset is synchronous and clears the matrix, the saturation flag and the
// controller. A stalled response holds the controller before it loads the
// next one, so no word is lost.
`include "offset_argmax_confusion_scorer_core_macros.svh"
module offset_argmax_confusion_scorer_core
   import oacs_pkg::*;
#(
   parameter int MAX_CLASSES = 4,
   parameter int COUNT_BITS  = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [PROB_BITS-1:0]         req_class_prob_0,
   input  logic [PROB_BITS-1:0]         req_class_prob_1,
   input  logic [PROB_BITS-1:0]         req_class_prob_2,
   input  logic [PROB_BITS-1:0]         req_class_prob_3,
   input  logic [1:0]                   req_true_class,
   input  logic                         req_is_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_predicted_class,
   output logic [SCORE_BITS-1:0]        rsp_score,
   output logic                         rsp_score_valid,
   output logic                         rsp_count_overflow,
   input  logic                         csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_data
);
   logic [2:0]                    class_count_ff;
   logic                          criterion_ff;
   logic signed [OFFSET_BITS-1:0] offset_ff [NUM_INPUTS];
   logic [PROB_BITS-1:0]          probs [NUM_INPUTS];
   oacs_cmd_type                  cmd;
   oacs_status_type               status;

   // Configuration registers; writes beyond the last index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         class_count_ff <= 3'd2;
         criterion_ff   <= CRIT_ACCURACY;
         for (int i = 0; i < NUM_INPUTS; i++) offset_ff[i] <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_CLASS_COUNT) class_count_ff <= csr_data[2:0];
         else if (csr_index == CSR_CRITERION) criterion_ff <= csr_data[0];
         else if (csr_index >= CSR_OFFSET_0 && csr_index <= CSR_OFFSET_3)
            offset_ff[2'(csr_index - CSR_OFFSET_0)] <= csr_data;
      end
   end

   assign probs[0] = req_class_prob_0;
   assign probs[1] = req_class_prob_1;
   assign probs[2] = req_class_prob_2;
   assign probs[3] = req_class_prob_3;

   oacs_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .status, .cmd
   );

   oacs_datapath #(.MAX_CLASSES(MAX_CLASSES), .COUNT_BITS(COUNT_BITS)) u_dp (
      .clock, .reset, .cmd, .status,
      .class_count(class_count_ff), .criterion(criterion_ff), .offsets(offset_ff),
      .probs, .true_class(req_true_class), .is_last(req_is_last),
      .predicted_class(rsp_predicted_class), .score(rsp_score),
      .score_valid(rsp_score_valid), .count_overflow(rsp_count_overflow)
   );

   // A score never exceeds one in Q1.16.
   `OACS_ASSERT_IMP(a_score_max, clock, reset, rsp_valid, rsp_score <= 17'd65536, "score above one")
   // A score is only reported on a word that carries one.
   `OACS_ASSERT_IMP(a_score_zero, clock, reset, rsp_valid && !rsp_score_valid, rsp_score == '0, "stray score")
   // A response pending under stall is held until taken, not dropped.
   `OACS_ASSERT_NEXT(a_no_take, clock, reset, rsp_valid && rsp_stall, rsp_valid, "response dropped")
endmodule
